FILE: rtl/core/vna_pkg.sv
package vna_pkg;

    localparam int SUM_BITS = 48;
    localparam int IDX_BITS = 10;
    localparam int OUT_BITS = 16;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_TRI  = 2'd1,
        KIND_READ = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [IDX_BITS-1:0]   index_a;
        logic [IDX_BITS-1:0]   index_b;
        logic [IDX_BITS-1:0]   index_c;
        logic                  bad;
        logic [15:0]           pos_x;
        logic [15:0]           pos_y;
        logic [15:0]           pos_z;
    } cmd_t;

endpackage

FILE: rtl/core/vna_front.sv
module vna_front #(
    parameter int VERTEX_COUNT = 1024
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_kind,
    input  logic [vna_pkg::IDX_BITS-1:0] s_index_a,
    input  logic [vna_pkg::IDX_BITS-1:0] s_index_b,
    input  logic [vna_pkg::IDX_BITS-1:0] s_index_c,
    input  logic [15:0]                 s_pos_x,
    input  logic [15:0]                 s_pos_y,
    input  logic [15:0]                 s_pos_z,
    output logic                        q_valid,
    input  logic                        q_ready,
    output vna_pkg::cmd_t               q_cmd
);

    vna_pkg::cmd_t q_reg [2];
    logic [1:0] cnt_reg;
    logic wp_reg, rp_reg;
    vna_pkg::cmd_t c;
    logic push, pop;

    always_comb begin
        c.kind    = vna_pkg::kind_t'(s_kind);
        c.index_a = s_index_a;
        c.index_b = s_index_b;
        c.index_c = s_index_c;
        c.pos_x   = s_pos_x;
        c.pos_y   = s_pos_y;
        c.pos_z   = s_pos_z;
        c.bad = (32'(s_index_a) >= VERTEX_COUNT) ||
                ((s_kind == vna_pkg::KIND_TRI) &&
                 ((32'(s_index_b) >= VERTEX_COUNT) || (32'(s_index_c) >= VERTEX_COUNT)));
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready && (s_kind != vna_pkg::KIND_NONE);
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_cmd   = q_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wp_reg] <= c;
        end
        if (!aresetn) begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

FILE: rtl/core/vna_norm.sv
module vna_norm (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [47:0] sx,
    input  logic [47:0] sy,
    input  logic [47:0] sz,
    output logic        done,
    output logic [15:0] nx,
    output logic [15:0] ny,
    output logic [15:0] nz,
    output logic        degen
);

    typedef enum logic [6:0] {
        N_IDLE  = 7'b0000001,
        N_SHIFT = 7'b0000010,
        N_SQ    = 7'b0000100,
        N_DIV   = 7'b0001000,
        N_SQRT  = 7'b0010000,
        N_NEXT  = 7'b0100000,
        N_DONE  = 7'b1000000
    } nst_t;

    nst_t st_reg;
    logic [47:0] m_reg [3];
    logic [2:0]  neg_reg;
    logic [33:0] sq_reg [3];
    logic [35:0] len_reg;
    logic [1:0]  i_reg;
    logic [63:0] rem_reg;
    logic [63:0] num_reg;
    logic [5:0]  step_reg;
    logic [33:0] sr_reg;
    logic [33:0] sres_reg;
    logic [15:0] o_reg [3];
    logic        degen_reg;
    logic [47:0] mx;
    logic [64:0] trial;
    logic [33:0] sres_next, sr_next;
    logic [17:0] r1;

    function automatic logic [47:0] mag(input logic [47:0] v);
        return v[47] ? 48'(-v) : v;
    endfunction

    assign mx = (m_reg[0] | m_reg[1] | m_reg[2]);
    assign trial = {rem_reg, num_reg[63]} - {29'd0, len_reg};

    always_comb begin
        logic [33:0] t;
        t = sres_reg | (34'd1 << {step_reg[4:0], 1'b0});
        sr_next = sr_reg;
        sres_next = sres_reg >> 1;
        if (sr_reg >= t) begin
            sr_next = sr_reg - t;
            sres_next = (sres_reg >> 1) | (34'd1 << {step_reg[4:0], 1'b0});
        end
    end

    assign r1 = 18'(sres_reg) + 18'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= N_IDLE;
        end else begin
            unique case (st_reg)
                N_IDLE: begin
                    if (start) begin
                        m_reg[0] <= mag(sx);
                        m_reg[1] <= mag(sy);
                        m_reg[2] <= mag(sz);
                        neg_reg  <= {sz[47], sy[47], sx[47]};
                        degen_reg <= (sx == '0) && (sy == '0) && (sz == '0);
                        st_reg <= N_SHIFT;
                    end
                end
                N_SHIFT: begin
                    if (degen_reg) begin
                        o_reg[0] <= '0;
                        o_reg[1] <= '0;
                        o_reg[2] <= '0;
                        st_reg <= N_DONE;
                    end else if (mx[47:16] != '0) begin
                        m_reg[0] <= m_reg[0] >> 1;
                        m_reg[1] <= m_reg[1] >> 1;
                        m_reg[2] <= m_reg[2] >> 1;
                    end else begin
                        i_reg <= '0;
                        st_reg <= N_SQ;
                    end
                end
                N_SQ: begin
                    sq_reg[i_reg] <= 34'(m_reg[i_reg][15:0] * m_reg[i_reg][15:0]);
                    if (i_reg == 2'd2) begin
                        i_reg <= '0;
                        st_reg <= N_NEXT;
                        len_reg <= 36'(m_reg[0][15:0] * m_reg[0][15:0]);
                    end else begin
                        i_reg <= i_reg + 2'd1;
                    end
                end
                N_NEXT: begin
                    st_reg <= N_DIV;
                    len_reg <= 36'(sq_reg[0]) + 36'(sq_reg[1]) + 36'(sq_reg[2]);
                    num_reg <= {sq_reg[i_reg], 30'd0};
                    rem_reg <= '0;
                    step_reg <= '0;
                end
                N_DIV: begin
                    num_reg <= {num_reg[62:0], ~trial[64]};
                    rem_reg <= trial[64] ? {rem_reg[62:0], num_reg[63]} : trial[63:0];
                    if (step_reg == 6'd63) begin
                        sr_reg <= 34'({num_reg[30:0], ~trial[64]});
                        sres_reg <= '0;
                        step_reg <= 6'd16;
                        st_reg <= N_SQRT;
                    end else begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                N_SQRT: begin
                    sr_reg <= sr_next;
                    sres_reg <= sres_next;
                    step_reg <= step_reg - 6'd1;
                    if (step_reg == 6'd0) begin
                        st_reg <= N_DONE;
                    end
                end
                N_DONE: begin
                    if (!degen_reg && step_reg == 6'h3F) begin
                        o_reg[i_reg] <= neg_reg[i_reg] ? 16'(-(r1 >> 1)) : 16'(r1 >> 1);
                        if (i_reg == 2'd2) begin
                            step_reg <= '0;
                        end else begin
                            i_reg <= i_reg + 2'd1;
                            st_reg <= N_NEXT;
                        end
                    end else begin
                        st_reg <= N_IDLE;
                    end
                end
                default: st_reg <= N_IDLE;
            endcase
        end
    end

    assign done  = (st_reg == N_DONE) && (degen_reg || step_reg != 6'h3F);
    assign nx    = o_reg[0];
    assign ny    = o_reg[1];
    assign nz    = o_reg[2];
    assign degen = degen_reg;

endmodule

FILE: rtl/core/vna_back.sv
module vna_back #(
    parameter int VERTEX_COUNT = 1024,
    parameter int COORD_BITS   = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  vna_pkg::cmd_t        q_cmd,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [9:0]           m_vertex_id,
    output logic [15:0]          m_norm_x,
    output logic [15:0]          m_norm_y,
    output logic [15:0]          m_norm_z,
    output logic                 m_degenerate
);

    localparam int AW = $clog2(VERTEX_COUNT);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int NW = PW + 1;

    typedef enum logic [9:0] {
        B_IDLE  = 10'b0000000001,
        B_RDP   = 10'b0000000010,
        B_DIFF  = 10'b0000000100,
        B_MUL   = 10'b0000001000,
        B_CROSS = 10'b0000010000,
        B_RDS   = 10'b0000100000,
        B_ADD   = 10'b0001000000,
        B_NORM  = 10'b0010000000,
        B_WAIT  = 10'b0100000000,
        B_OUT   = 10'b1000000000
    } bst_t;

    bst_t st_reg;
    vna_pkg::cmd_t cmd_reg;
    logic [3*COORD_BITS-1:0] pos_mem [VERTEX_COUNT];
    logic [47:0] sx_mem [VERTEX_COUNT];
    logic [47:0] sy_mem [VERTEX_COUNT];
    logic [47:0] sz_mem [VERTEX_COUNT];
    logic [3*COORD_BITS-1:0] prd_reg;
    logic [47:0] sxr_reg, syr_reg, szr_reg;
    logic [1:0] k_reg;
    logic signed [COORD_BITS-1:0] p_reg [3][3];
    logic signed [DW-1:0] u_reg [3], w_reg [3];
    logic signed [PW-1:0] pr_reg [6];
    logic signed [NW-1:0] n_reg [3];
    logic [AW-1:0] addr;
    logic [AW-1:0] ld_addr;
    logic nstart, ndone, ndeg;
    logic [15:0] nnx, nny, nnz;

    function automatic logic [47:0] sat(input logic [47:0] a, input logic signed [NW-1:0] b);
        logic signed [63:0] s;
        s = 64'($signed(a)) + 64'(b);
        if (s > 64'sh0000_7FFF_FFFF_FFFF) return {1'b0, {47{1'b1}}};
        if (s < -64'sh0000_8000_0000_0000) return {1'b1, 47'd0};
        return s[47:0];
    endfunction

    always_comb begin
        case (k_reg)
            2'd0: addr = AW'(cmd_reg.index_a);
            2'd1: addr = AW'(cmd_reg.index_b);
            default: addr = AW'(cmd_reg.index_c);
        endcase
    end

    assign ld_addr = AW'(q_cmd.index_a);
    assign q_ready = (st_reg == B_IDLE);
    assign nstart  = (st_reg == B_NORM);

    always_ff @(posedge aclk) begin
        if (st_reg == B_IDLE && q_valid && q_cmd.kind == vna_pkg::KIND_LOAD && !q_cmd.bad) begin
            pos_mem[ld_addr] <= {COORD_BITS'(q_cmd.pos_z),
                COORD_BITS'(q_cmd.pos_y), COORD_BITS'(q_cmd.pos_x)};
            sx_mem[ld_addr] <= '0;
            sy_mem[ld_addr] <= '0;
            sz_mem[ld_addr] <= '0;
        end
        if (st_reg == B_RDP) prd_reg <= pos_mem[addr];
        if (st_reg == B_RDS) begin
            sxr_reg <= sx_mem[addr];
            syr_reg <= sy_mem[addr];
            szr_reg <= sz_mem[addr];
        end
        if (st_reg == B_ADD) begin
            sx_mem[addr] <= sat(sxr_reg, n_reg[0]);
            sy_mem[addr] <= sat(syr_reg, n_reg[1]);
            sz_mem[addr] <= sat(szr_reg, n_reg[2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= B_IDLE;
            m_valid <= 1'b0;
            k_reg   <= '0;
        end else begin
            unique case (st_reg)
                B_IDLE: begin
                    if (q_valid) begin
                        cmd_reg <= q_cmd;
                        k_reg <= '0;
                        if (q_cmd.kind == vna_pkg::KIND_TRI && !q_cmd.bad) st_reg <= B_RDP;
                        else if (q_cmd.kind == vna_pkg::KIND_READ) st_reg <= B_RDS;
                    end
                end
                B_RDP: begin
                    st_reg <= B_DIFF;
                end
                B_DIFF: begin
                    p_reg[k_reg][0] <= prd_reg[COORD_BITS-1:0];
                    p_reg[k_reg][1] <= prd_reg[2*COORD_BITS-1:COORD_BITS];
                    p_reg[k_reg][2] <= prd_reg[3*COORD_BITS-1:2*COORD_BITS];
                    if (k_reg == 2'd2) begin
                        st_reg <= B_MUL;
                    end else begin
                        k_reg <= k_reg + 2'd1;
                        st_reg <= B_RDP;
                    end
                end
                B_MUL: begin
                    for (int j = 0; j < 3; j++) begin
                        u_reg[j] <= DW'(p_reg[2][j]) - DW'(p_reg[1][j]);
                        w_reg[j] <= DW'(p_reg[0][j]) - DW'(p_reg[1][j]);
                    end
                    st_reg <= B_CROSS;
                    k_reg <= '0;
                end
                B_CROSS: begin
                    if (k_reg == 2'd0) begin
                        pr_reg[0] <= u_reg[1] * w_reg[2];
                        pr_reg[1] <= u_reg[2] * w_reg[1];
                        pr_reg[2] <= u_reg[2] * w_reg[0];
                        pr_reg[3] <= u_reg[0] * w_reg[2];
                        pr_reg[4] <= u_reg[0] * w_reg[1];
                        pr_reg[5] <= u_reg[1] * w_reg[0];
                        k_reg <= 2'd1;
                    end else begin
                        n_reg[0] <= NW'(pr_reg[0]) - NW'(pr_reg[1]);
                        n_reg[1] <= NW'(pr_reg[2]) - NW'(pr_reg[3]);
                        n_reg[2] <= NW'(pr_reg[4]) - NW'(pr_reg[5]);
                        k_reg <= '0;
                        st_reg <= B_RDS;
                    end
                end
                B_RDS: begin
                    st_reg <= (cmd_reg.kind == vna_pkg::KIND_READ) ? B_NORM : B_ADD;
                    if (cmd_reg.kind == vna_pkg::KIND_READ && cmd_reg.bad) st_reg <= B_OUT;
                end
                B_ADD: begin
                    if (k_reg == 2'd2) begin
                        st_reg <= B_IDLE;
                    end else begin
                        k_reg <= k_reg + 2'd1;
                        st_reg <= B_RDS;
                    end
                end
                B_NORM: st_reg <= B_WAIT;
                B_WAIT: if (ndone) st_reg <= B_OUT;
                B_OUT: begin
                    if (!m_valid) begin
                        m_valid      <= 1'b1;
                        m_vertex_id  <= cmd_reg.index_a;
                        m_norm_x     <= cmd_reg.bad ? '0 : nnx;
                        m_norm_y     <= cmd_reg.bad ? '0 : nny;
                        m_norm_z     <= cmd_reg.bad ? '0 : nnz;
                        m_degenerate <= cmd_reg.bad | ndeg;
                        st_reg       <= B_IDLE;
                    end
                end
                default: st_reg <= B_IDLE;
            endcase
            if (m_valid && m_ready) m_valid <= 1'b0;
        end
    end

    vna_norm u_norm (
        .aclk(aclk), .aresetn(aresetn), .start(nstart),
        .sx(sxr_reg), .sy(syr_reg), .sz(szr_reg),
        .done(ndone), .nx(nnx), .ny(nny), .nz(nnz), .degen(ndeg)
    );

endmodule

FILE: rtl/core/vertex_normal_accumulate.sv
// A load writes the position memory and clears the vertex's sums; a triangle does three
// position reads, the cross product and three read-modify-write passes of the sum memories;
// a read runs the bit-serial divider and square root once per axis, and a read of an
// all-zero sum skips the divider and square root.
// A two-entry queue lets new transactions be accepted while the back end works.
module vertex_normal_accumulate #(
    parameter int VERTEX_COUNT = 1024,
    parameter int COORD_BITS   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [9:0]  s_index_a,
    input  logic [9:0]  s_index_b,
    input  logic [9:0]  s_index_c,
    input  logic [15:0] s_pos_x,
    input  logic [15:0] s_pos_y,
    input  logic [15:0] s_pos_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [9:0]  m_vertex_id,
    output logic [15:0] m_norm_x,
    output logic [15:0] m_norm_y,
    output logic [15:0] m_norm_z,
    output logic        m_degenerate
);

    logic q_valid, q_ready;
    vna_pkg::cmd_t q_cmd;

    vna_front #(.VERTEX_COUNT(VERTEX_COUNT)) u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_kind(s_kind), .s_index_a(s_index_a), .s_index_b(s_index_b),
        .s_index_c(s_index_c), .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_pos_z(s_pos_z),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    vna_back #(.VERTEX_COUNT(VERTEX_COUNT), .COORD_BITS(COORD_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_cmd(q_cmd), .m_valid(m_valid), .m_ready(m_ready),
        .m_vertex_id(m_vertex_id), .m_norm_x(m_norm_x), .m_norm_y(m_norm_y),
        .m_norm_z(m_norm_z), .m_degenerate(m_degenerate)
    );

    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> (m_norm_x == '0 && m_norm_y == '0 && m_norm_z == '0))
        else $error("degenerate result with nonzero normal");

    a_norm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_norm_x) <= 16384 && $signed(m_norm_x) >= -16384))
        else $error("normal component out of range");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_vertex_id))
        else $error("result dropped while stalled");

endmodule

FILE: tb/sv/tb_vertex_normal_accumulate.sv
module tb_vertex_normal_accumulate;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NVERT = 1024;
    localparam int RANDOM_ITEMS = 630;
    localparam int PHASE_LEN = 217;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 800;
    localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO = -SUM_HI - 1;

    typedef struct {
        vna_pkg::kind_t kind;
        logic [9:0]  a;
        logic [9:0]  b;
        logic [9:0]  c;
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] pz;
    } mesh_op_t;

    typedef struct {
        logic [9:0]  id;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic        deg;
    } vnormal_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_kind;
    logic [9:0]  s_index_a;
    logic [9:0]  s_index_b;
    logic [9:0]  s_index_c;
    logic [15:0] s_pos_x;
    logic [15:0] s_pos_y;
    logic [15:0] s_pos_z;
    logic        m_valid;
    logic        m_ready;
    logic [9:0]  m_vertex_id;
    logic [15:0] m_norm_x;
    logic [15:0] m_norm_y;
    logic [15:0] m_norm_z;
    logic        m_degenerate;

    vertex_normal_accumulate dut (.*);

    mesh_op_t op_queue[$];
    vnormal_t normal_queue[$];
    logic signed [15:0] vpos[NVERT][3];
    longint vsum[NVERT][3];
    bit loaded[NVERT];
    int loaded_list[$];
    int sent;
    int mismatches;
    int stall_count;
    logic in_taken;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic longint sat_sum(longint v);
        if (v > SUM_HI) return SUM_HI;
        if (v < SUM_LO) return SUM_LO;
        return v;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic vnormal_t unit_normal(int v);
        vnormal_t r;
        longint unsigned mag[3];
        longint unsigned top;
        longint unsigned len2;
        longint unsigned q;
        longint unsigned h;
        int k;
        r.id = v[9:0];
        r.nx = '0;
        r.ny = '0;
        r.nz = '0;
        r.deg = 1'b1;
        for (int i = 0; i < 3; i++) mag[i] = vsum[v][i] < 0 ? -vsum[v][i] : vsum[v][i];
        top = mag[0];
        if (mag[1] > top) top = mag[1];
        if (mag[2] > top) top = mag[2];
        if (top == 0) return r;
        k = 0;
        while ((top >> k) >= 64'd65536) k++;
        len2 = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] >>= k;
            len2 += mag[i] * mag[i];
        end
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] * mag[i]) << 30) / len2;
            h = (root_floor(q) + 1) >> 1;
            if (vsum[v][i] < 0) h = -h;
            if (i == 0) r.nx = h[15:0];
            else if (i == 1) r.ny = h[15:0];
            else r.nz = h[15:0];
        end
        r.deg = 1'b0;
        return r;
    endfunction

    task automatic apply_op(mesh_op_t op);
        longint u[3];
        longint w[3];
        longint n[3];
        int a;
        int b;
        int c;
        a = op.a;
        b = op.b;
        c = op.c;
        case (op.kind)
            vna_pkg::KIND_LOAD: begin
                vpos[a][0] = op.px;
                vpos[a][1] = op.py;
                vpos[a][2] = op.pz;
                for (int i = 0; i < 3; i++) vsum[a][i] = 0;
            end
            vna_pkg::KIND_TRI: begin
                for (int i = 0; i < 3; i++) begin
                    u[i] = longint'(vpos[c][i]) - longint'(vpos[b][i]);
                    w[i] = longint'(vpos[a][i]) - longint'(vpos[b][i]);
                end
                n[0] = u[1] * w[2] - u[2] * w[1];
                n[1] = u[2] * w[0] - u[0] * w[2];
                n[2] = u[0] * w[1] - u[1] * w[0];
                for (int i = 0; i < 3; i++) begin
                    vsum[a][i] = sat_sum(vsum[a][i] + n[i]);
                    vsum[b][i] = sat_sum(vsum[b][i] + n[i]);
                    vsum[c][i] = sat_sum(vsum[c][i] + n[i]);
                end
            end
            vna_pkg::KIND_READ: normal_queue.push_back(unit_normal(a));
            default: ;
        endcase
    endtask

    task automatic add_op(vna_pkg::kind_t kind, int a, int b, int c, int px, int py, int pz);
        mesh_op_t op;
        op.kind = kind;
        op.a = a[9:0];
        op.b = b[9:0];
        op.c = c[9:0];
        op.px = px[15:0];
        op.py = py[15:0];
        op.pz = pz[15:0];
        if (kind == vna_pkg::KIND_LOAD && !loaded[a]) begin
            loaded[a] = 1'b1;
            loaded_list.push_back(a);
        end
        op_queue.push_back(op);
    endtask

    function automatic int pick_vertex();
        int n;
        n = loaded_list.size();
        if ($urandom_range(99) < 70 && n > 12)
            return loaded_list[$urandom_range(n - 1, n - 12)];
        return loaded_list[$urandom_range(n - 1, 0)];
    endfunction

    function automatic int coord();
        if ($urandom_range(99) < 70) return $urandom_range(4095) - 2048;
        return $urandom_range(65535);
    endfunction

    task automatic add_random_op();
        int r;
        r = $urandom_range(99);
        if (r < 20) begin
            add_op(vna_pkg::KIND_LOAD, $urandom_range(NVERT - 1), $urandom_range(1023),
                   $urandom_range(1023), coord(), coord(), coord());
        end else if (r < 62) begin
            if ($urandom_range(99) < 8)
                add_op(vna_pkg::KIND_TRI, pick_vertex(), pick_vertex(), 0, 0, 0, 0);
            else
                add_op(vna_pkg::KIND_TRI, pick_vertex(), pick_vertex(), pick_vertex(),
                       $urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
            if (op_queue[$].c == 0 && !loaded[0])
                op_queue[$].c = op_queue[$].a;
        end else if (r < 95) begin
            add_op(vna_pkg::KIND_READ, pick_vertex(), $urandom_range(1023),
                   $urandom_range(1023), $urandom_range(65535), $urandom_range(65535),
                   $urandom_range(65535));
        end else begin
            add_op(vna_pkg::KIND_NONE, $urandom_range(1023), $urandom_range(1023),
                   $urandom_range(1023), $urandom_range(65535), $urandom_range(65535),
                   $urandom_range(65535));
        end
    endtask

    always @(negedge aclk) begin
        int send_idle;
        int recv_idle;
        mesh_op_t op;
        send_idle = sent < PHASE_LEN ? 36 : (sent < 2 * PHASE_LEN ? 49 : 0);
        recv_idle = sent < PHASE_LEN ? 49 : (sent < 2 * PHASE_LEN ? 36 : 0);
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                if (op_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
                    op = op_queue.pop_front();
                    s_kind <= op.kind;
                    s_index_a <= op.a;
                    s_index_b <= op.b;
                    s_index_c <= op.c;
                    s_pos_x <= op.px;
                    s_pos_y <= op.py;
                    s_pos_z <= op.pz;
                    s_valid <= 1'b1;
                    sent++;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= $urandom_range(99) >= recv_idle;
        end
    end

    always @(posedge aclk) begin
        mesh_op_t op;
        vnormal_t exp_n;
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                op.kind = vna_pkg::kind_t'(s_kind);
                op.a = s_index_a;
                op.b = s_index_b;
                op.c = s_index_c;
                op.px = s_pos_x;
                op.py = s_pos_y;
                op.pz = s_pos_z;
                apply_op(op);
            end
            if (m_valid && m_ready) begin
                if (normal_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: vertex %0d", m_vertex_id);
                end else begin
                    exp_n = normal_queue.pop_front();
                    if (m_vertex_id !== exp_n.id || m_norm_x !== exp_n.nx ||
                        m_norm_y !== exp_n.ny || m_norm_z !== exp_n.nz ||
                        m_degenerate !== exp_n.deg) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected id %0d n (%0d %0d %0d) deg %0d, got id %0d n (%0d %0d %0d) deg %0d",
                                     exp_n.id, $signed(exp_n.nx), $signed(exp_n.ny),
                                     $signed(exp_n.nz), exp_n.deg, m_vertex_id,
                                     $signed(m_norm_x), $signed(m_norm_y),
                                     $signed(m_norm_z), m_degenerate);
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_count <= 0;
            end else if (stall_count >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                stall_count <= stall_count + 1;
            end
        end
    end

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        s_kind = '0;
        s_index_a = '0;
        s_index_b = '0;
        s_index_c = '0;
        s_pos_x = '0;
        s_pos_y = '0;
        s_pos_z = '0;
        in_taken = 1'b0;
        sent = 0;
        mismatches = 0;
        stall_count = 0;

        add_op(vna_pkg::KIND_READ, 0, 0, 0, 0, 0, 0);
        op_queue.delete();
        add_op(vna_pkg::KIND_LOAD, 0, 1023, 1023, 32767, 32767, 32767);
        add_op(vna_pkg::KIND_LOAD, 1, 0, 0, -32768, -32768, -32768);
        add_op(vna_pkg::KIND_LOAD, 2, 0, 0, 32767, -32768, 0);
        add_op(vna_pkg::KIND_LOAD, 1023, 1023, 1023, 0, 0, 0);
        add_op(vna_pkg::KIND_LOAD, 512, 511, 256, 256, 0, 0);
        add_op(vna_pkg::KIND_LOAD, 511, 0, 0, 0, 256, 0);
        add_op(vna_pkg::KIND_READ, 1023, 0, 0, 0, 0, 0);
        add_op(vna_pkg::KIND_TRI, 0, 1, 2, 0, 0, 0);
        add_op(vna_pkg::KIND_TRI, 0, 0, 1, 0, 0, 0);
        add_op(vna_pkg::KIND_TRI, 512, 1023, 511, 0, 0, 0);
        add_op(vna_pkg::KIND_TRI, 1023, 1, 0, 0, 0, 0);
        add_op(vna_pkg::KIND_NONE, 1023, 1023, 1023, -1, -1, -1);
        add_op(vna_pkg::KIND_READ, 0, 1023, 1023, -1, -1, -1);
        add_op(vna_pkg::KIND_READ, 1, 0, 0, 0, 0, 0);
        add_op(vna_pkg::KIND_READ, 2, 0, 0, 0, 0, 0);
        add_op(vna_pkg::KIND_READ, 512, 0, 0, 0, 0, 0);
        add_op(vna_pkg::KIND_READ, 511, 0, 0, 0, 0, 0);
        add_op(vna_pkg::KIND_READ, 1023, 0, 0, 0, 0, 0);
        add_op(vna_pkg::KIND_LOAD, 0, 0, 0, 100, -200, 300);
        add_op(vna_pkg::KIND_READ, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < RANDOM_ITEMS; i++) add_random_op();

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        while (op_queue.size() > 0 || s_valid) @(posedge aclk);
        while (normal_queue.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && normal_queue.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: vertex_normal_accumulate.f
rtl/core/vna_pkg.sv
rtl/core/vna_front.sv
rtl/core/vna_norm.sv
rtl/core/vna_back.sv
rtl/core/vertex_normal_accumulate.sv
tb/sv/tb_vertex_normal_accumulate.sv
